FILE: rtl/sci_pkg.sv
package sci_pkg;

   // field widths
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_BITS   = 33;

   // half-unit coordinates, spans and products
   localparam int HALF_W = COORD_BITS + 3;
   localparam int LEN_W  = COORD_BITS + 2;
   localparam int P1_W   = HALF_W + LEN_W;
   localparam int P2_W   = 2 * LEN_W;
   localparam int D_W    = P1_W + 1;

   // divider widths and depth
   localparam int DEN_W           = LEN_W + 1;
   localparam int REM_W           = LEN_W + 2;
   localparam int QUO_W           = FRAC_BITS + 2;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // side result carried alongside the divider
   typedef struct packed {
      logic                en_valid;
      logic                en_is_y;
      logic [OUT_BITS-1:0] en_line;
      logic [OUT_BITS-1:0] en_base;
      logic                ex_valid;
      logic                ex_is_y;
      logic [OUT_BITS-1:0] ex_line;
      logic [OUT_BITS-1:0] ex_base;
      logic [3:0]          sides;
   } meta_type;

   // grid coordinate to output fixed point, wrapping to the output width
   function automatic logic [OUT_BITS-1:0] fix_coord(input logic signed [COORD_BITS:0] c);
      logic signed [COORD_BITS+FRAC_BITS+OUT_BITS:0] wide;
      wide = c;
      wide = wide <<< FRAC_BITS;
      return wide[OUT_BITS-1:0];
   endfunction

endpackage

FILE: rtl/sci_div.sv
module sci_div
   import sci_pkg::*;
(
   input  logic             clock,
   input  logic             advance,
   input  logic [REM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [REM_W-1:0] rem_ff [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];
   logic [REM_W-1:0] rem_in [DIV_STAGES];
   logic [QUO_W-1:0] quo_in [DIV_STAGES];

   // restoring division, STEPS_PER_STAGE quotient bits per stage
   always_comb begin
      logic [REM_W-1:0] r;
      logic [QUO_W-1:0] q;
      logic [DEN_W-1:0] dv;
      logic             ge;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r  = (s == 0) ? num : rem_ff[s-1];
         q  = (s == 0) ? '0 : quo_ff[s-1];
         dv = (s == 0) ? den : den_ff[s-1];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if (s * STEPS_PER_STAGE + j < QUO_W) begin
               ge = (r >= REM_W'(dv));
               if (ge) begin
                  r = r - REM_W'(dv);
               end
               r = r << 1;
               q = {q[QUO_W-2:0], ge};
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= (s == 0) ? den : den_ff[s-1];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

FILE: rtl/segment_cell_intersection.sv
// Segment versus unit cell intersection. One segment/cell pair is taken per
// cycle and its result passes through input math, multiplies, side selection,
// the pipelined entry and exit dividers (two quotient bits per stage), then the
// output register. The whole pipeline holds while a result waits on rsp_ready,
// so nothing is lost.
// Points not found read zero; exit_sides is bit0 left, bit1 right, bit2 top,
// bit3 bottom.
module segment_cell_intersection
   import sci_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_cell_x,
   input  logic signed [COORD_BITS-1:0] req_cell_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_entry_valid,
   output logic signed [OUT_BITS-1:0]   rsp_entry_x,
   output logic signed [OUT_BITS-1:0]   rsp_entry_y,
   output logic                         rsp_exit_valid,
   output logic signed [OUT_BITS-1:0]   rsp_exit_x,
   output logic signed [OUT_BITS-1:0]   rsp_exit_y,
   output logic [3:0]                   rsp_exit_sides
);

   logic rsp_valid_ff;
   logic advance;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------- stage 1: half-unit geometry
   logic signed [HALF_W-1:0] sx, sy, ex, ey, cx2, cy2, minx2, miny2;
   logic signed [HALF_W-1:0] spanx, spany;
   logic                     right_in, down_in, aligned;
   logic signed [HALF_W-1:0] nl_in, nr_in, nt_in, nb_in, tl, tr, tt, tb;

   always_comb begin
      sx = HALF_W'(req_start_x);
      sy = HALF_W'(req_start_y);
      ex = HALF_W'(req_end_x);
      ey = HALF_W'(req_end_y);
      cx2 = HALF_W'(req_cell_x) <<< 1;
      cy2 = HALF_W'(req_cell_y) <<< 1;
      right_in = req_start_x < req_end_x;
      down_in  = req_start_y < req_end_y;
      aligned  = (right_in == down_in);
      minx2 = ((right_in ? sx : ex) <<< 1) + HALF_W'(1);
      miny2 = ((down_in ? sy : ey) <<< 1) + HALF_W'(1);
      spanx = (right_in ? ex - sx : sx - ex) <<< 1;
      spany = (down_in ? ey - sy : sy - ey) <<< 1;
      nl_in = cx2 - minx2;
      nr_in = cx2 + HALF_W'(2) - minx2;
      nt_in = cy2 - miny2;
      nb_in = cy2 + HALF_W'(2) - miny2;
      tl = aligned ? nl_in : spanx - nl_in;
      tr = aligned ? nr_in : spanx - nr_in;
      tt = aligned ? nt_in : spany - nt_in;
      tb = aligned ? nb_in : spany - nb_in;
   end

   logic                         s1_valid_ff;
   logic                         s1_right_ff, s1_down_ff;
   logic [LEN_W-1:0]             s1_lenx_ff, s1_leny_ff;
   logic signed [HALF_W-1:0]     s1_nl_ff, s1_nr_ff, s1_nt_ff, s1_nb_ff;
   logic [LEN_W-1:0]             s1_tl_ff, s1_tr_ff, s1_tt_ff, s1_tb_ff;
   logic signed [HALF_W-1:0]     s1_diffx_ff, s1_diffy_ff;
   logic signed [COORD_BITS-1:0] s1_cx_ff, s1_cy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_right_ff <= right_in;
         s1_down_ff  <= down_in;
         s1_lenx_ff  <= spanx[LEN_W-1:0];
         s1_leny_ff  <= spany[LEN_W-1:0];
         s1_nl_ff    <= nl_in;
         s1_nr_ff    <= nr_in;
         s1_nt_ff    <= nt_in;
         s1_nb_ff    <= nb_in;
         s1_tl_ff    <= tl[LEN_W-1:0];
         s1_tr_ff    <= tr[LEN_W-1:0];
         s1_tt_ff    <= tt[LEN_W-1:0];
         s1_tb_ff    <= tb[LEN_W-1:0];
         s1_diffx_ff <= minx2 - cx2;
         s1_diffy_ff <= miny2 - cy2;
         s1_cx_ff    <= req_cell_x;
         s1_cy_ff    <= req_cell_y;
      end
   end

   // ---------------- stage 2: products
   logic signed [P1_W-1:0] px_in, py_in;

   always_comb begin
      px_in = P1_W'(s1_diffy_ff * $signed({1'b0, s1_lenx_ff}));
      py_in = P1_W'(s1_diffx_ff * $signed({1'b0, s1_leny_ff}));
   end

   logic                         s2_valid_ff;
   logic                         s2_right_ff, s2_down_ff;
   logic [LEN_W-1:0]             s2_lenx_ff, s2_leny_ff;
   logic signed [HALF_W-1:0]     s2_nl_ff, s2_nr_ff, s2_nt_ff, s2_nb_ff;
   logic signed [P1_W-1:0]       s2_px_ff, s2_py_ff;
   logic [P2_W-1:0]              s2_pl_ff, s2_pr_ff, s2_pt_ff, s2_pb_ff;
   logic signed [COORD_BITS-1:0] s2_cx_ff, s2_cy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_right_ff <= s1_right_ff;
         s2_down_ff  <= s1_down_ff;
         s2_lenx_ff  <= s1_lenx_ff;
         s2_leny_ff  <= s1_leny_ff;
         s2_nl_ff    <= s1_nl_ff;
         s2_nr_ff    <= s1_nr_ff;
         s2_nt_ff    <= s1_nt_ff;
         s2_nb_ff    <= s1_nb_ff;
         s2_px_ff    <= px_in;
         s2_py_ff    <= py_in;
         s2_pl_ff    <= s1_leny_ff * s1_tl_ff;
         s2_pr_ff    <= s1_leny_ff * s1_tr_ff;
         s2_pt_ff    <= s1_lenx_ff * s1_tt_ff;
         s2_pb_ff    <= s1_lenx_ff * s1_tb_ff;
         s2_cx_ff    <= s1_cx_ff;
         s2_cy_ff    <= s1_cy_ff;
      end
   end

   // ---------------- stage 3: side tests and selection
   logic signed [D_W-1:0]    dl, dr, dt, db, lim_x, lim_y;
   logic signed [HALF_W-1:0] lenx_s, leny_s;
   logic                     hl, hr, ht, hb, en_x, en_y, ex_x, ex_y;
   logic [OUT_BITS-1:0]      fx0, fx1, fy0, fy1;
   meta_type                 meta_in;
   logic [REM_W-1:0]         en_num_in, ex_num_in;
   logic [DEN_W-1:0]         en_den_in, ex_den_in;

   always_comb begin
      dl = D_W'(s2_px_ff) + D_W'(s2_pl_ff);
      dr = D_W'(s2_px_ff) + D_W'(s2_pr_ff);
      dt = D_W'(s2_py_ff) + D_W'(s2_pt_ff);
      db = D_W'(s2_py_ff) + D_W'(s2_pb_ff);
      lenx_s = $signed({1'b0, s2_lenx_ff});
      leny_s = $signed({1'b0, s2_leny_ff});
      lim_x  = D_W'({s2_lenx_ff, 1'b0});
      lim_y  = D_W'({s2_leny_ff, 1'b0});
      hl = (s2_nl_ff > 0) && (s2_nl_ff < lenx_s) && (dl >= 0) && (dl <= lim_x);
      hr = (s2_nr_ff > 0) && (s2_nr_ff < lenx_s) && (dr >= 0) && (dr <= lim_x);
      ht = (s2_nt_ff > 0) && (s2_nt_ff < leny_s) && (dt >= 0) && (dt <= lim_y);
      hb = (s2_nb_ff > 0) && (s2_nb_ff < leny_s) && (db >= 0) && (db <= lim_y);
      fx0 = fix_coord((COORD_BITS+1)'(s2_cx_ff));
      fx1 = fix_coord((COORD_BITS+1)'(s2_cx_ff) + (COORD_BITS+1)'(1));
      fy0 = fix_coord((COORD_BITS+1)'(s2_cy_ff));
      fy1 = fix_coord((COORD_BITS+1)'(s2_cy_ff) + (COORD_BITS+1)'(1));
      en_x = s2_right_ff ? hl : hr;
      en_y = s2_down_ff ? ht : hb;
      ex_x = s2_right_ff ? hr : hl;
      ex_y = s2_down_ff ? hb : ht;

      // later sides win: a y side overrides an x side
      meta_in.en_valid = en_x || en_y;
      meta_in.en_is_y  = en_y;
      meta_in.ex_valid = ex_x || ex_y;
      meta_in.ex_is_y  = ex_y;
      if (en_y) begin
         meta_in.en_line = s2_down_ff ? fy0 : fy1;
         meta_in.en_base = fx0;
         en_num_in = s2_down_ff ? dt[REM_W-1:0] : db[REM_W-1:0];
         en_den_in = {s2_leny_ff, 1'b0};
      end else begin
         meta_in.en_line = s2_right_ff ? fx0 : fx1;
         meta_in.en_base = fy0;
         en_num_in = s2_right_ff ? dl[REM_W-1:0] : dr[REM_W-1:0];
         en_den_in = {s2_lenx_ff, 1'b0};
      end
      if (ex_y) begin
         meta_in.ex_line = s2_down_ff ? fy1 : fy0;
         meta_in.ex_base = fx0;
         ex_num_in = s2_down_ff ? db[REM_W-1:0] : dt[REM_W-1:0];
         ex_den_in = {s2_leny_ff, 1'b0};
      end else begin
         meta_in.ex_line = s2_right_ff ? fx1 : fx0;
         meta_in.ex_base = fy0;
         ex_num_in = s2_right_ff ? dr[REM_W-1:0] : dl[REM_W-1:0];
         ex_den_in = {s2_lenx_ff, 1'b0};
      end
      meta_in.sides = {s2_down_ff && hb, !s2_down_ff && ht, s2_right_ff && hr,
                       !s2_right_ff && hl};
   end

   logic             s3_valid_ff;
   meta_type         s3_meta_ff;
   logic [REM_W-1:0] s3_en_num_ff, s3_ex_num_ff;
   logic [DEN_W-1:0] s3_en_den_ff, s3_ex_den_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_meta_ff   <= meta_in;
         s3_en_num_ff <= en_num_in;
         s3_ex_num_ff <= ex_num_in;
         s3_en_den_ff <= en_den_in;
         s3_ex_den_ff <= ex_den_in;
      end
   end

   // ---------------- divider stages
   logic [QUO_W-1:0] en_quo, ex_quo;

   sci_div u_en_div (
      .clock   (clock),
      .advance (advance),
      .num     (s3_en_num_ff),
      .den     (s3_en_den_ff),
      .quo     (en_quo)
   );

   sci_div u_ex_div (
      .clock   (clock),
      .advance (advance),
      .num     (s3_ex_num_ff),
      .den     (s3_ex_den_ff),
      .quo     (ex_quo)
   );

   logic     dv_valid_ff [DIV_STAGES];
   meta_type dv_meta_ff  [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_meta_ff[s] <= (s == 0) ? s3_meta_ff : dv_meta_ff[s-1];
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= dv_valid_ff[DIV_STAGES-1];
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_valid_ff[s] <= (s == 0) ? s3_valid_ff : dv_valid_ff[s-1];
         end
      end
   end

   // ---------------- output: round half up, place the crossing point
   meta_type            mo;
   logic [QUO_W-1:0]    en_q1, ex_q1;
   logic [OUT_BITS-1:0] en_var, ex_var;
   logic [OUT_BITS-1:0] enx_in, eny_in, exx_in, exy_in;

   always_comb begin
      mo = dv_meta_ff[DIV_STAGES-1];
      en_q1 = (en_quo + QUO_W'(1)) >> 1;
      ex_q1 = (ex_quo + QUO_W'(1)) >> 1;
      en_var = mo.en_base + OUT_BITS'(en_q1);
      ex_var = mo.ex_base + OUT_BITS'(ex_q1);
      enx_in = '0;
      eny_in = '0;
      exx_in = '0;
      exy_in = '0;
      if (mo.en_valid) begin
         enx_in = mo.en_is_y ? en_var : mo.en_line;
         eny_in = mo.en_is_y ? mo.en_line : en_var;
      end
      if (mo.ex_valid) begin
         exx_in = mo.ex_is_y ? ex_var : mo.ex_line;
         exy_in = mo.ex_is_y ? mo.ex_line : ex_var;
      end
   end

   logic                en_valid_ff, ex_valid_ff;
   logic [OUT_BITS-1:0] enx_ff, eny_ff, exx_ff, exy_ff;
   logic [3:0]          sides_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         en_valid_ff <= mo.en_valid;
         ex_valid_ff <= mo.ex_valid;
         enx_ff      <= enx_in;
         eny_ff      <= eny_in;
         exx_ff      <= exx_in;
         exy_ff      <= exy_in;
         sides_ff    <= mo.sides;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_valid = en_valid_ff;
   assign rsp_entry_x     = $signed(enx_ff);
   assign rsp_entry_y     = $signed(eny_ff);
   assign rsp_exit_valid  = ex_valid_ff;
   assign rsp_exit_x      = $signed(exx_ff);
   assign rsp_exit_y      = $signed(exy_ff);
   assign rsp_exit_sides  = sides_ff;

endmodule
